@@ rtl/core/gpio_pkg.sv @@
// Package with the shared types, codes and constants of the GPIO port.
`default_nettype none

package gpio_pkg;

  localparam int unsigned PinCount = 32;
  localparam int unsigned DataWidth = 32;

  // Bits of a 32-bit word that belong to implemented pins.
  localparam logic [DataWidth-1:0] PinMask =
      (PinCount >= DataWidth) ? {DataWidth{1'b1}}
                              : DataWidth'((64'd1 << PinCount) - 64'd1);

  typedef enum logic [1:0] {
    ModeNone  = 2'd0,
    ModeWrite = 2'd1,
    ModeRead  = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    SelDir    = 4'd0,
    SelLoad   = 4'd1,
    SelSet    = 4'd2,
    SelClear  = 4'd3,
    SelToggle = 4'd4,
    SelPins   = 4'd5,
    SelIrqEn  = 4'd6,
    SelRise   = 4'd7,
    SelFall   = 4'd8,
    SelStatus = 4'd9
  } reg_sel_e;

  typedef enum logic [1:0] {
    CfgDirection = 2'd0,
    CfgIrqEnable = 2'd1,
    CfgRise      = 2'd2,
    CfgFall      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]           mode;
    logic [3:0]           reg_select;
    logic [DataWidth-1:0] write_data;
    logic [DataWidth-1:0] pin_levels;
  } item_t;

  typedef struct packed {
    logic [DataWidth-1:0] direction;
    logic [DataWidth-1:0] irq_enable;
    logic [DataWidth-1:0] rise_enable;
    logic [DataWidth-1:0] fall_enable;
    logic [DataWidth-1:0] out_value;
    logic [DataWidth-1:0] last_pins;
    logic [DataWidth-1:0] edge_status;
  } state_t;

  typedef struct packed {
    logic [DataWidth-1:0] read_data;
    logic [DataWidth-1:0] pin_drive;
    logic [DataWidth-1:0] pin_enable;
    logic                 irq_line;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/gpio_port_with_edge_irq.sv @@
// Top level of the 32-pin GPIO port with set/clear/toggle and edge interrupts.
`default_nettype none

// Each item carries one sample of the pins and may carry one bus access (a
// write that loads, sets, clears or toggles the output register or writes a
// direction or mask register, or a read of one register). Every item gives
// exactly one result item that shows the read data, the output register, the
// direction register and the interrupt line as they stand after that item.
// The block takes one item per clock cycle in steady state while the result
// side is not stalled. An item goes through an input register and then a
// result register; its result is on the outputs once it has moved into the
// result register, which a stall on the result side can hold back. The input
// stalls only because of the result side:
// in_stall_o rises when both the input register and the result register hold
// items and out_stall_i is high. Reading the status register clears the bits
// it returned; an edge found by the same item stays set. The first sample
// after reset is compared against all-zero pins, so high pins count as rising
// edges. The configuration port writes the direction and the three masks; it
// is meant to be used while no item is in flight. No clearing pass is needed
// after reset.
module gpio_port_with_edge_irq
  import gpio_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,

  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire  [1:0]           mode_i,
  input  wire  [3:0]           reg_select_i,
  input  wire  [DataWidth-1:0] write_data_i,
  input  wire  [DataWidth-1:0] pin_levels_i,

  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic [DataWidth-1:0] read_data_o,
  output logic [DataWidth-1:0] pin_drive_o,
  output logic [DataWidth-1:0] pin_enable_o,
  output logic                 irq_line_o,

  input  wire                  cfg_we_i,
  input  wire  [1:0]           cfg_index_i,
  input  wire  [DataWidth-1:0] cfg_wdata_i
);

  logic    s1_valid_q, s1_valid_d;
  item_t   s1_item_q;
  logic    out_valid_q, out_valid_d;
  result_t out_res_q;
  state_t  state_q, state_d;
  state_t  step_nxt;
  result_t step_res;
  logic    out_free;
  logic    s1_advance;
  logic    in_accept;

  // The result register can take a new result when it is empty or being read.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_advance = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  gpio_step u_step (
    .cur_i  (state_q),
    .item_i (s1_item_q),
    .nxt_o  (step_nxt),
    .res_o  (step_res)
  );

  always_comb begin
    s1_valid_d = s1_advance ? 1'b0 : s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (s1_advance) begin
      out_valid_d = 1'b1;
    end
  end

  // Items update the state as they leave the input register. Configuration
  // writes land only while no item is leaving it; a write that meets one is lost.
  always_comb begin
    state_d = state_q;
    if (s1_advance) begin
      state_d = step_nxt;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgDirection: state_d.direction   = cfg_wdata_i & PinMask;
        CfgIrqEnable: state_d.irq_enable  = cfg_wdata_i & PinMask;
        CfgRise:      state_d.rise_enable = cfg_wdata_i & PinMask;
        CfgFall:      state_d.fall_enable = cfg_wdata_i & PinMask;
        default:      state_d             = state_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q.mode       <= mode_i;
      s1_item_q.reg_select <= reg_select_i;
      s1_item_q.write_data <= write_data_i;
      s1_item_q.pin_levels <= pin_levels_i;
    end
    if (s1_advance) begin
      out_res_q <= step_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = out_res_q.read_data;
  assign pin_drive_o  = out_res_q.pin_drive;
  assign pin_enable_o = out_res_q.pin_enable;
  assign irq_line_o   = out_res_q.irq_line;

`ifndef SYNTHESIS
  // A full pipeline facing a stalled consumer must push back on the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input not stalled while both stages are blocked");

  // Results of items that are not reads carry zero read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_advance && s1_item_q.mode != ModeRead) |=> (out_res_q.read_data == '0))
    else $error("non-read item produced nonzero read data");

  // A fresh result shows the output and direction registers it left behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance |=> (out_res_q.pin_drive == state_q.out_value &&
                    out_res_q.pin_enable == state_q.direction))
    else $error("result does not match the updated port state");

  // The interrupt line of a fresh result follows status and irq mask.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance |=> (out_res_q.irq_line ==
                    (|(state_q.edge_status & state_q.irq_enable))))
    else $error("interrupt line inconsistent with status and mask");
`endif

endmodule

`default_nettype wire

@@ rtl/core/gpio_step.sv @@
// Next-state and result logic of the GPIO port for one item.
`default_nettype none

module gpio_step
  import gpio_pkg::*;
(
  input  state_t  cur_i,
  input  item_t   item_i,
  output state_t  nxt_o,
  output result_t res_o
);

  logic [DataWidth-1:0] data;
  logic [DataWidth-1:0] pins;
  logic [DataWidth-1:0] edges;
  logic [DataWidth-1:0] rd;
  logic                 clear_status;
  state_t               nxt;

  assign data  = item_i.write_data & PinMask;
  assign pins  = item_i.pin_levels & PinMask;
  assign edges = ((pins & ~cur_i.last_pins & cur_i.rise_enable) |
                  (~pins & cur_i.last_pins & cur_i.fall_enable)) & PinMask;

  always_comb begin
    rd           = '0;
    clear_status = 1'b0;
    nxt          = cur_i;
    case (item_i.mode)
      ModeRead: begin
        case (item_i.reg_select)
          SelDir:    rd = cur_i.direction;
          SelLoad:   rd = cur_i.out_value;
          SelSet:    rd = cur_i.out_value;
          SelClear:  rd = cur_i.out_value;
          SelToggle: rd = cur_i.out_value;
          SelPins:   rd = pins;
          SelIrqEn:  rd = cur_i.irq_enable;
          SelRise:   rd = cur_i.rise_enable;
          SelFall:   rd = cur_i.fall_enable;
          SelStatus: begin
            rd           = cur_i.edge_status;
            clear_status = 1'b1;
          end
          default:   rd = '0;
        endcase
      end
      ModeWrite: begin
        case (item_i.reg_select)
          SelDir:    nxt.direction   = data;
          SelLoad:   nxt.out_value   = data;
          SelSet:    nxt.out_value   = cur_i.out_value | data;
          SelClear:  nxt.out_value   = cur_i.out_value & ~data;
          SelToggle: nxt.out_value   = cur_i.out_value ^ data;
          SelIrqEn:  nxt.irq_enable  = data;
          SelRise:   nxt.rise_enable = data;
          SelFall:   nxt.fall_enable = data;
          default:   nxt             = cur_i;
        endcase
      end
      default: nxt = cur_i;
    endcase
    // A status read clears the old bits, but an edge seen now still sticks.
    nxt.edge_status = ((clear_status ? '0 : cur_i.edge_status) | edges) & PinMask;
    nxt.last_pins   = pins;
  end

  assign nxt_o = nxt;

  assign res_o.read_data  = rd;
  assign res_o.pin_drive  = nxt.out_value;
  assign res_o.pin_enable = nxt.direction;
  assign res_o.irq_line   = |(nxt.edge_status & nxt.irq_enable);

endmodule

`default_nettype wire
